FILE: src/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg: shared types and constants of the bitstream field reader
// Field widths, operation and status codes, the command queue entry and the
// back-end state type.
// ----------------------------------------------------------------------------
package bfr_pkg;

   localparam int MODE_W   = 3;
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 13;
   localparam int VALUE_W  = 16;
   localparam int STATUS_W = 2;
   localparam int REM_W    = 16;
   localparam int POS_W    = 13;

   // bits needed to hold a field length 0..VALUE_W
   localparam int NBITS_W  = $clog2(VALUE_W + 1);
   // bit offset + field length + rounding up to whole bytes
   localparam int NEED_W   = $clog2(2 * (BYTE_W - 1) + VALUE_W + 1);
   // width in bits of the window over the bytes a field can touch
   localparam int WIN_W    = BYTE_W * ((VALUE_W + 2 * BYTE_W - 2) / BYTE_W);

   localparam int DEF_STORE_BYTES    = 4096;
   localparam int DEF_MAX_FIELD_BITS = 16;
   localparam int QUEUE_DEPTH        = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND = 3'd0,
      MODE_READ   = 3'd1,
      MODE_ALIGN  = 3'd2,
      MODE_SKIP   = 3'd3,
      MODE_REWIND = 3'd4,
      MODE_CLEAR  = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_UNDERRUN = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic {
      BK_IDLE  = 1'b0,
      BK_FETCH = 1'b1
   } bk_state_type;

   typedef struct packed {
      mode_type             mode;
      logic [BYTE_W-1:0]    data_byte;
      logic [COUNT_W-1:0]   count;
      logic [NBITS_W-1:0]   nbits;
      logic                 lsb_first;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_stat_type;

endpackage

FILE: src/bfr_ifs.sv
// ----------------------------------------------------------------------------
// bfr_ifs: request and response channels of the bitstream field reader
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface bfr_req_if;
   logic                          valid;
   logic                          ready;
   logic [bfr_pkg::MODE_W-1:0]    mode;
   logic [bfr_pkg::BYTE_W-1:0]    data_byte;
   logic [bfr_pkg::COUNT_W-1:0]   count;
   logic                          lsb_first;

   modport source (output valid, output mode, output data_byte, output count,
                   output lsb_first, input ready);
   modport sink   (input valid, input mode, input data_byte, input count,
                   input lsb_first, output ready);
endinterface

interface bfr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bfr_pkg::VALUE_W-1:0]   field_value;
   logic [bfr_pkg::STATUS_W-1:0]  status;
   logic [bfr_pkg::REM_W-1:0]     remaining_bits;
   logic [bfr_pkg::POS_W-1:0]     byte_position;

   modport source (output valid, output field_value, output status,
                   output remaining_bits, output byte_position, input ready);
   modport sink   (input valid, input field_value, input status,
                   input remaining_bits, input byte_position, output ready);
endinterface

FILE: src/bfr_ram.sv
// ----------------------------------------------------------------------------
// bfr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/bfr_front.sv
// ----------------------------------------------------------------------------
// bfr_front: request decode
// Takes request transactions while the queue has room, decodes the operation
// and clamps the field length.
// ----------------------------------------------------------------------------
module bfr_front #(
   parameter int MAX_FIELD_BITS = bfr_pkg::DEF_MAX_FIELD_BITS
) (
   bfr_req_if.sink               req_bus,
   input  bfr_pkg::q_stat_type   q_stat,
   output logic                  push,
   output bfr_pkg::cmd_type      push_entry
);

   logic [bfr_pkg::NBITS_W-1:0] nbits;

   always_comb begin
      if (req_bus.count > bfr_pkg::COUNT_W'(MAX_FIELD_BITS)) begin
         nbits = bfr_pkg::NBITS_W'(MAX_FIELD_BITS);
      end else begin
         nbits = req_bus.count[bfr_pkg::NBITS_W-1:0];
      end
   end

   assign req_bus.ready = !q_stat.full;
   assign push          = req_bus.valid && !q_stat.full;

   assign push_entry.mode      = bfr_pkg::mode_type'(req_bus.mode);
   assign push_entry.data_byte = req_bus.data_byte;
   assign push_entry.count     = req_bus.count;
   assign push_entry.nbits     = nbits;
   assign push_entry.lsb_first = req_bus.lsb_first;

endmodule

FILE: src/bfr_queue.sv
// ----------------------------------------------------------------------------
// bfr_queue: command queue between decode and execution
// Small FIFO of decoded commands; the head stays put until popped.
// ----------------------------------------------------------------------------
module bfr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bfr_pkg::cmd_type      push_entry,
   input  logic                  pop,
   output bfr_pkg::cmd_type      head,
   output bfr_pkg::q_stat_type   q_stat
);

   localparam int QD  = bfr_pkg::QUEUE_DEPTH;
   localparam int PW  = (QD > 1) ? $clog2(QD) : 1;
   localparam int CNW = $clog2(QD + 1);

   bfr_pkg::cmd_type entries_ff [QD];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [CNW-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = (wptr_ff == PW'(QD - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(QD - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wptr_ff] <= push_entry;
      end
   end

   assign head         = entries_ff[rptr_ff];
   assign q_stat.empty = (cnt_ff == '0);
   assign q_stat.full  = (cnt_ff == CNW'(QD));

endmodule

FILE: src/bfr_back.sv
// ----------------------------------------------------------------------------
// bfr_back: command execution
// Holds the byte store, fill count and bit cursor, executes the command at
// the queue head and registers the response.
// ----------------------------------------------------------------------------
module bfr_back #(
   parameter int STORE_BYTES = bfr_pkg::DEF_STORE_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bfr_pkg::cmd_type      ent,
   input  bfr_pkg::q_stat_type   q_stat,
   output logic                  q_pop,
   bfr_rsp_if.source             rsp_bus
);

   localparam int CW     = $clog2(STORE_BYTES + 2);
   localparam int AW     = $clog2(STORE_BYTES);
   localparam int UW     = CW + 3;
   localparam int SW     = ((CW > bfr_pkg::COUNT_W) ? CW : bfr_pkg::COUNT_W) + 1;
   localparam int BW     = bfr_pkg::NEED_W - 3;
   localparam int BYTE_W = bfr_pkg::BYTE_W;
   localparam int WIN_W  = bfr_pkg::WIN_W;
   localparam int VAL_W  = bfr_pkg::VALUE_W;

   bfr_pkg::bk_state_type state_ff, state_in;

   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     cb_ff, cb_in;
   logic [2:0]        bit_ff, bit_in;
   logic [CW-1:0]     zlim_ff, zlim_in;    // bytes below this were cleared
   logic [BW-1:0]     iss_ff, iss_in;
   logic [BW-1:0]     rcv_ff, rcv_in;
   logic [WIN_W-1:0]  win_ff, win_in;
   logic              zpend_ff, zpend_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]           value_ff;
   bfr_pkg::status_type        status_ff;
   logic [bfr_pkg::REM_W-1:0]  rem_ff;
   logic [bfr_pkg::POS_W-1:0]  pos_ff;

   logic                          out_free;
   logic                          start;
   logic                          go_fetch;
   logic                          done;
   logic [VAL_W-1:0]              res_value;
   bfr_pkg::status_type           res_status;
   logic [UW-1:0]                 rem_now;
   logic [UW-1:0]                 used;
   logic [bfr_pkg::NEED_W-1:0]    need;
   logic [BW-1:0]                 nby;
   logic                          last;
   logic [SW-1:0]                 skip_sum;
   logic [CW-1:0]                 rd_addr;
   logic [BYTE_W-1:0]             raw_byte;
   logic [BYTE_W-1:0]             cur_byte;
   logic [WIN_W-1:0]              win_next;
   logic [WIN_W-1:0]              win_sh;
   logic [VAL_W-1:0]              field;
   logic [UW-1:0]                 new_pos;

   logic                 ram_we;
   logic                 ram_re;
   logic [BYTE_W-1:0]    ram_rdata;

   function automatic logic [UW-1:0] bits_left(input logic [CW-1:0] f,
                                                input logic [CW-1:0] c,
                                                input logic [2:0]    b);
      logic [UW-1:0] total;
      logic [UW-1:0] taken;
      total = {f, 3'b000};
      taken = {c, b};
      return (taken >= total) ? '0 : total - taken;
   endfunction

   bfr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (fill_ff[AW-1:0]),
      .wdata (ent.data_byte),
      .re    (ram_re),
      .raddr (rd_addr[AW-1:0]),
      .rdata (ram_rdata)
   );

   // ---- datapath helpers ----
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign start    = (state_ff == bfr_pkg::BK_IDLE) && !q_stat.empty && out_free;
   assign rem_now  = bits_left(fill_ff, cb_ff, bit_ff);
   assign used     = {cb_ff, bit_ff};
   assign need     = bfr_pkg::NEED_W'(bit_ff) + bfr_pkg::NEED_W'(ent.nbits)
                     + bfr_pkg::NEED_W'(BYTE_W - 1);
   assign nby      = need[bfr_pkg::NEED_W-1:3];
   assign last     = ((rcv_ff + 1'b1) == nby);
   assign skip_sum = SW'(cb_ff) + SW'(ent.count);
   assign rd_addr  = cb_ff + ((state_ff == bfr_pkg::BK_FETCH) ? CW'(iss_ff) : '0);
   assign raw_byte = zpend_ff ? '0 : ram_rdata;
   assign new_pos  = used + UW'(ent.nbits);

   always_comb begin
      for (int i = 0; i < BYTE_W; i++) begin
         cur_byte[i] = ent.lsb_first ? raw_byte[BYTE_W-1-i] : raw_byte[i];
      end
   end

   // bytes land left-aligned in arrival order
   always_comb begin
      win_next = win_ff;
      for (int j = 0; j < WIN_W / BYTE_W; j++) begin
         if (rcv_ff == BW'(j)) begin
            win_next[WIN_W-1-j*BYTE_W -: BYTE_W] = cur_byte;
         end
      end
   end

   assign win_sh = win_next << bit_ff;
   assign field  = win_sh[WIN_W-1 -: VAL_W] >> (bfr_pkg::NBITS_W'(VAL_W) - ent.nbits);

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfr_pkg::BK_IDLE: begin
            if (go_fetch) begin
               state_in = bfr_pkg::BK_FETCH;
            end
         end
         bfr_pkg::BK_FETCH: begin
            if (done) begin
               state_in = bfr_pkg::BK_IDLE;
            end
         end
         default: state_in = bfr_pkg::BK_IDLE;
      endcase
   end

   // ---- outputs and datapath updates ----
   always_comb begin
      fill_in    = fill_ff;
      cb_in      = cb_ff;
      bit_in     = bit_ff;
      zlim_in    = zlim_ff;
      iss_in     = iss_ff;
      rcv_in     = rcv_ff;
      win_in     = win_ff;
      zpend_in   = zpend_ff;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      go_fetch   = 1'b0;
      done       = 1'b0;
      res_value  = '0;
      res_status = bfr_pkg::ST_OK;
      unique case (state_ff)
         bfr_pkg::BK_IDLE: begin
            if (start) begin
               done = 1'b1;
               unique case (ent.mode)
                  bfr_pkg::MODE_APPEND: begin
                     if (fill_ff >= CW'(STORE_BYTES)) begin
                        res_status = bfr_pkg::ST_FULL;
                     end else begin
                        ram_we  = 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  bfr_pkg::MODE_READ: begin
                     if (UW'(ent.nbits) > rem_now) begin
                        res_status = bfr_pkg::ST_UNDERRUN;
                     end else if (ent.nbits != '0) begin
                        done     = 1'b0;
                        go_fetch = 1'b1;
                        ram_re   = 1'b1;
                        zpend_in = (rd_addr < zlim_ff);
                        iss_in   = BW'(1);
                        rcv_in   = '0;
                     end
                  end
                  bfr_pkg::MODE_ALIGN: begin
                     if (bit_ff != 3'd0) begin
                        bit_in = 3'd0;
                        cb_in  = cb_ff + 1'b1;
                     end
                  end
                  bfr_pkg::MODE_SKIP: begin
                     if (skip_sum > SW'(fill_ff)) begin
                        res_status = bfr_pkg::ST_UNDERRUN;
                     end else begin
                        cb_in = CW'(skip_sum);
                     end
                  end
                  bfr_pkg::MODE_REWIND: begin
                     cb_in  = '0;
                     bit_in = 3'd0;
                  end
                  bfr_pkg::MODE_CLEAR: begin
                     // everything filled so far reads back as zero from now on
                     cb_in   = '0;
                     bit_in  = 3'd0;
                     zlim_in = fill_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         bfr_pkg::BK_FETCH: begin
            rcv_in = rcv_ff + 1'b1;
            win_in = win_next;
            if (last) begin
               done      = 1'b1;
               res_value = field;
               cb_in     = new_pos[UW-1:3];
               bit_in    = new_pos[2:0];
            end else begin
               ram_re   = 1'b1;
               zpend_in = (rd_addr < zlim_ff);
               iss_in   = iss_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign q_pop = done;

   always_comb begin
      if (done) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfr_pkg::BK_IDLE;
         fill_ff      <= '0;
         cb_ff        <= '0;
         bit_ff       <= '0;
         zlim_ff      <= '0;
         iss_ff       <= '0;
         rcv_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cb_ff        <= cb_in;
         bit_ff       <= bit_in;
         zlim_ff      <= zlim_in;
         iss_ff       <= iss_in;
         rcv_ff       <= rcv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      zpend_ff <= zpend_in;
      if (done) begin
         value_ff  <= res_value;
         status_ff <= res_status;
         rem_ff    <= bfr_pkg::REM_W'(bits_left(fill_in, cb_in, bit_in));
         pos_ff    <= bfr_pkg::POS_W'(cb_ff);
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.field_value    = value_ff;
   assign rsp_bus.status         = status_ff;
   assign rsp_bus.remaining_bits = rem_ff;
   assign rsp_bus.byte_position  = pos_ff;

endmodule

FILE: src/bitstream_field_reader.sv
// ----------------------------------------------------------------------------
// bitstream_field_reader: byte store with a bit cursor
// Each request appends a byte, reads a 0..16 bit field (MSB-first or
// LSB-first within a byte, first bit lands in the MSB of the field), aligns
// the cursor, skips bytes, rewinds or clears, and returns exactly one
// response. Requests are decoded into a two-entry queue; a command stays in
// the queue until it retires, so one more transaction is taken while a read
// is fetching and two while a response waits on the output.
// The executer completes append, align, skip, rewind, clear and reads that
// fail or have zero length without a fetch; a field read touching k stored
// bytes (k = 1..3) fetches them one by one through the single registered read
// port of the byte store. Clear makes bytes filled before it read back as
// zero through a boundary register, with no pass over the store after reset.
// ----------------------------------------------------------------------------
module bitstream_field_reader #(
   parameter int STORE_BYTES    = bfr_pkg::DEF_STORE_BYTES,
   parameter int MAX_FIELD_BITS = bfr_pkg::DEF_MAX_FIELD_BITS
) (
   input  logic         clock,
   input  logic         reset,
   bfr_req_if.sink      req_bus,
   bfr_rsp_if.source    rsp_bus
);

   logic                  q_push;
   logic                  q_pop;
   bfr_pkg::cmd_type      push_entry;
   bfr_pkg::cmd_type      head;
   bfr_pkg::q_stat_type   q_stat;

   bfr_front #(
      .MAX_FIELD_BITS (MAX_FIELD_BITS)
   ) u_front (
      .req_bus    (req_bus),
      .q_stat     (q_stat),
      .push       (q_push),
      .push_entry (push_entry)
   );

   bfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   bfr_back #(
      .STORE_BYTES (STORE_BYTES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .ent     (head),
      .q_stat  (q_stat),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

`ifndef SYNTH
   // executer never retires a command the queue does not hold
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("queue popped while empty");

   // field length is clamped before it enters the queue
   a_nbits_clamped: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (push_entry.nbits <= bfr_pkg::NBITS_W'(MAX_FIELD_BITS)))
      else $error("unclamped field length queued");

   // only a successful read carries field bits
   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.field_value != '0)) |->
         (rsp_bus.status == bfr_pkg::ST_OK))
      else $error("field value on failed transaction");
`endif

endmodule
